/* src/sbusd_pkg.sv */
// ----------------------------------------------------------------------------
// sbusd_pkg
// Shared types and constants of the S.BUS frame decoder: byte codes, field
// widths, controller states and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sbusd_pkg;

   // field widths of the channels
   localparam int RX_W    = 8;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 11;

   // frame delimiters
   localparam logic [RX_W-1:0] SYNC_BYTE  = 8'h0F;
   localparam logic [RX_W-1:0] END_BYTE_0 = 8'h00;
   localparam logic [RX_W-1:0] END_BYTE_1 = 8'h04;
   localparam logic [RX_W-1:0] END_BYTE_2 = 8'h14;
   localparam logic [RX_W-1:0] END_BYTE_3 = 8'h24;
   localparam logic [RX_W-1:0] END_BYTE_4 = 8'h34;

   // frame sequencer states
   typedef enum logic [2:0] {
      ST_HUNT,
      ST_DATA,
      ST_FLAGS,
      ST_END,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_pos;
      logic store_byte;
      logic store_flags;
      logic clear_channel;
      logic next_channel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_start;
      logic end_ok;
      logic pos_last;
      logic chan_last;
   } status_type;

   // one of the accepted end-of-frame codes
   function automatic logic end_byte_ok(input logic [RX_W-1:0] b);
      end_byte_ok = (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
                    (b == END_BYTE_3) || (b == END_BYTE_4);
   endfunction

endpackage

/* src/sbusd_intf.sv */
// ----------------------------------------------------------------------------
// sbusd request and response channels
// Valid/ready channels: received bytes in, decoded channel results out.
// ----------------------------------------------------------------------------
interface sbusd_req_if
   import sbusd_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [RX_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbusd_rsp_if
   import sbusd_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] channel_index;
   logic [VALUE_W-1:0] channel_value;
   logic               digital_ch17;
   logic               digital_ch18;
   logic               signal_lost;
   logic               failsafe_active;
   logic               last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output digital_ch17, output digital_ch18, output signal_lost,
                   output failsafe_active, output last_channel, input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input digital_ch17, input digital_ch18, input signal_lost,
                   input failsafe_active, input last_channel, output ready);
endinterface

/* src/sbus_frame_decoder.sv */
// Bytes are taken in every state but result emission; the first channel result is shown
// the cycle after the end byte is taken.
// Throughput: NUM_CHANNELS results per good frame, one per cycle while the
// result side is ready; no byte is taken during those cycles (the shared
// payload shift register releases one channel per cycle).
// Reset: synchronous, returns to hunting for the start byte; payload is not cleared.
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// S.BUS receiver frame decoder: collects a frame from the byte stream and
// emits its proportional channels with the digital and status flags.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
   import sbusd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 22,
   parameter int NUM_CHANNELS  = 16,
   parameter int CHANNEL_WIDTH = 11
) (
   input logic         clock,
   input logic         reset,
   sbusd_req_if.sink   req_bus,
   sbusd_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   sbusd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sbusd_dp #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .NUM_CHANNELS  (NUM_CHANNELS),
      .CHANNEL_WIDTH (CHANNEL_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .rx_byte         (req_bus.rx_byte),
      .cmd             (cmd),
      .status          (status),
      .channel_index   (rsp_bus.channel_index),
      .channel_value   (rsp_bus.channel_value),
      .digital_ch17    (rsp_bus.digital_ch17),
      .digital_ch18    (rsp_bus.digital_ch18),
      .signal_lost     (rsp_bus.signal_lost),
      .failsafe_active (rsp_bus.failsafe_active),
      .last_channel    (rsp_bus.last_channel)
   );

   // no byte is taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request taken while results pending");

   // the final result closes the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_channel) |=> !rsp_bus.valid)
      else $error("results continue past the last channel");

   // a burst continues with the next channel index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_channel) |=>
         (rsp_bus.valid &&
          rsp_bus.channel_index == $past(rsp_bus.channel_index) + 4'd1))
      else $error("channel index did not advance");

endmodule

/* src/sbusd_ctrl.sv */
// ----------------------------------------------------------------------------
// sbusd_ctrl
// Frame sequencer: hunts for the start byte, steps through data, flags and
// end byte, then releases the channel results one per cycle while the result side is ready.
// ----------------------------------------------------------------------------
module sbusd_ctrl
   import sbusd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
            if (req_valid && status.is_start) begin
               cmd.clear_pos = 1'b1;
               state_in      = ST_DATA;
            end
         end
         ST_DATA: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_byte = 1'b1;
               if (status.pos_last) begin
                  state_in = ST_FLAGS;
               end
            end
         end
         ST_FLAGS: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_flags = 1'b1;
               state_in        = ST_END;
            end
         end
         ST_END: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.end_ok) begin
                  cmd.clear_channel = 1'b1;
                  state_in          = ST_EMIT;
               end else begin
                  // bad end code: drop the frame
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.next_channel = 1'b1;
               if (status.chan_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

/* src/sbusd_dp.sv */
// ----------------------------------------------------------------------------
// sbusd_dp
// Frame datapath: payload shift register, byte and channel counters, flags
// register. Channels are taken from the low end of the payload, which shifts
// right by one channel width per result.
// ----------------------------------------------------------------------------
module sbusd_dp
   import sbusd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 22,
   parameter int NUM_CHANNELS  = 16,
   parameter int CHANNEL_WIDTH = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [RX_W-1:0]    rx_byte,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [INDEX_W-1:0] channel_index,
   output logic [VALUE_W-1:0] channel_value,
   output logic               digital_ch17,
   output logic               digital_ch18,
   output logic               signal_lost,
   output logic               failsafe_active,
   output logic               last_channel
);

   localparam int PayloadW = PAYLOAD_BYTES * RX_W;
   localparam int PosW     = $clog2(PAYLOAD_BYTES);
   localparam logic [PosW-1:0]    PosLast = PosW'(PAYLOAD_BYTES - 1);
   localparam logic [INDEX_W-1:0] ChLast  = INDEX_W'(NUM_CHANNELS - 1);

   logic [PayloadW-1:0] payload_ff;
   logic [PayloadW-1:0] payload_in;
   logic [PosW-1:0]     pos_ff;
   logic [PosW-1:0]     pos_in;
   logic [INDEX_W-1:0]  chan_ff;
   logic [INDEX_W-1:0]  chan_in;
   logic [3:0]          flags_ff;
   logic [3:0]          flags_in;

   // payload: bytes enter at the top, channels leave at the bottom
   always_comb begin
      payload_in = payload_ff;
      if (cmd.store_byte) begin
         payload_in = {rx_byte, payload_ff[PayloadW-1:RX_W]};
      end else if (cmd.next_channel) begin
         payload_in = payload_ff >> CHANNEL_WIDTH;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   // counters and flags
   always_comb begin
      pos_in   = pos_ff;
      chan_in  = chan_ff;
      flags_in = flags_ff;
      if (cmd.clear_pos) begin
         pos_in = '0;
      end else if (cmd.store_byte) begin
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.clear_channel) begin
         chan_in = '0;
      end else if (cmd.next_channel) begin
         chan_in = chan_ff + 1'b1;
      end
      if (cmd.store_flags) begin
         flags_in = rx_byte[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         chan_ff  <= '0;
         flags_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         flags_ff <= flags_in;
      end
   end

   // status back to the sequencer
   assign status.is_start  = (rx_byte == SYNC_BYTE);
   assign status.end_ok    = end_byte_ok(rx_byte);
   assign status.pos_last  = (pos_ff == PosLast);
   assign status.chan_last = (chan_ff == ChLast);

   // result fields, all straight from registers
   assign channel_index   = chan_ff;
   assign channel_value   = VALUE_W'(payload_ff[CHANNEL_WIDTH-1:0]);
   assign digital_ch17    = flags_ff[0];
   assign digital_ch18    = flags_ff[1];
   assign signal_lost     = flags_ff[2];
   assign failsafe_active = flags_ff[3];
   assign last_channel    = (chan_ff == ChLast);

endmodule
